// ===== src/sap_pkg.sv =====
// Package for the sweep-and-prune broadphase: sizes, codes and item types.
// No dependencies.
`timescale 1ns / 1ps
package sap_pkg;

  localparam int MaxBodies  = 8;
  localparam int CoordWidth = 16;
  localparam int BodyWidth  = 3;
  localparam int EpCap      = 2 * MaxBodies;
  localparam int EpIdxW     = $clog2(EpCap);
  localparam int EpCntW     = $clog2(EpCap + 1);
  localparam int BodyIdxW   = $clog2(MaxBodies);
  localparam int ResultCap  = 28;
  localparam int ResCntW    = $clog2(ResultCap + 1);

  localparam logic [2:0] ActAdd    = 3'd0;
  localparam logic [2:0] ActRemove = 3'd1;
  localparam logic [2:0] ActBounds = 3'd2;
  localparam logic [2:0] ActSweep  = 3'd3;
  localparam logic [2:0] ActQuery  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StPresent = 2'd1;
  localparam logic [1:0] StAbsent  = 2'd2;

  typedef struct packed {
    logic [2:0]                   action;
    logic [2:0]                   body;
    logic signed [CoordWidth-1:0] x_min;
    logic signed [CoordWidth-1:0] x_max;
    logic signed [CoordWidth-1:0] y_min;
    logic signed [CoordWidth-1:0] y_max;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       pair_valid;
    logic [2:0] first_body;
    logic [2:0] second_body;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] value;
    logic                         is_min;
    logic [BodyIdxW-1:0]          owner;
  } endpoint_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input item
    logic do_add;
    logic do_bounds;
    logic rm_start;   // clear compaction pointers and pairs
    logic rm_step;    // one compaction step
    logic rm_finish;
    logic fill_step;  // refresh one endpoint value
    logic sort_init;  // i = 1
    logic sort_load;  // j = i
    logic sort_step;  // one compare/swap
    logic sort_next;  // i++
    logic q_init;
    logic q_step;     // advance pair scan
    logic ctr_clr;    // clear generic index
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       body_ok;     // index in range
    logic       present;
    logic       rm_done;
    logic       fill_done;
    logic       sort_done;   // i >= count
    logic       inner_done;  // j==0 or mover > left
    logic       q_done;      // scan exhausted or cap reached
    logic       q_hit;       // current pair reported
    logic       q_any;       // something reported so far
    logic [2:0] q_a;
    logic [2:0] q_b;
  } sts_t;

endpackage

// ===== src/sap_datapath.sv =====
// Datapath of the sweep-and-prune broadphase: bounds, endpoint list, pair bits.
// Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_datapath import sap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  cmd_t     cmd_i,
  output sts_t     sts_o
);

  logic signed [CoordWidth-1:0] xlo_q [MaxBodies];
  logic signed [CoordWidth-1:0] xhi_q [MaxBodies];
  logic signed [CoordWidth-1:0] ylo_q [MaxBodies];
  logic signed [CoordWidth-1:0] yhi_q [MaxBodies];
  logic [MaxBodies-1:0]         present_q;
  endpoint_t                    ep_q [EpCap];
  logic [EpCntW-1:0]            cnt_q;
  logic [MaxBodies-1:0]         pair_q [MaxBodies];
  in_item_t                     it_q;

  logic [EpCntW-1:0]   ri_q;   // read pointer / fill / sort outer
  logic [EpCntW-1:0]   wi_q;   // write pointer / sort inner j
  logic [BodyIdxW:0]   qa_q, qb_q;
  logic [ResCntW-1:0]  qn_q;
  logic                qany_q;

  logic [BodyIdxW-1:0] bidx;
  assign bidx = it_q.body[BodyIdxW-1:0];

  endpoint_t mover, left;
  logic [EpIdxW-1:0] jidx, jm1;
  assign jidx  = wi_q[EpIdxW-1:0];
  assign jm1   = jidx - 1'b1;
  assign mover = ep_q[jidx];
  assign left  = ep_q[jm1];

  logic qa_ok, qb_ok, q_ov, q_pair;
  logic [BodyIdxW-1:0] qa, qb;
  assign qa    = qa_q[BodyIdxW-1:0];
  assign qb    = qb_q[BodyIdxW-1:0];
  assign qa_ok = qa_q < (BodyIdxW+1)'(MaxBodies);
  assign qb_ok = qb_q < (BodyIdxW+1)'(MaxBodies);
  assign q_ov  = (ylo_q[qa] <= yhi_q[qb]) && (ylo_q[qb] <= yhi_q[qa]);
  assign q_pair = qa_ok && qb_ok && pair_q[qa][qb];

  always_comb begin
    sts_o            = '0;
    sts_o.action     = it_q.action;
    sts_o.body_ok    = {1'b0, it_q.body} < 4'(MaxBodies);
    sts_o.present    = present_q[bidx];
    sts_o.rm_done    = ri_q >= cnt_q;
    sts_o.fill_done  = ri_q >= cnt_q;
    sts_o.sort_done  = ri_q >= cnt_q;
    sts_o.inner_done = (wi_q == '0) || (mover.value > left.value);
    sts_o.q_done     = !qa_ok || (qn_q >= ResCntW'(ResultCap));
    sts_o.q_hit      = q_pair && q_ov && qn_q < ResCntW'(ResultCap);
    sts_o.q_any      = qany_q;
    sts_o.q_a        = 3'(qa_q);
    sts_o.q_b        = 3'(qb_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxBodies; k++) begin
        xlo_q[k] <= '0; xhi_q[k] <= '0; ylo_q[k] <= '0; yhi_q[k] <= '0;
        pair_q[k] <= '0;
      end
      for (int k = 0; k < EpCap; k++) ep_q[k] <= '0;
      present_q <= '0;
      cnt_q     <= '0;
      ri_q      <= '0;
      wi_q      <= '0;
      qa_q      <= '0;
      qb_q      <= '0;
      qn_q      <= '0;
      qany_q    <= 1'b0;
    end else begin
      if (cmd_i.ctr_clr) ri_q <= '0;
      if (cmd_i.do_bounds) begin
        xlo_q[bidx] <= it_q.x_min;
        xhi_q[bidx] <= it_q.x_max;
        ylo_q[bidx] <= it_q.y_min;
        yhi_q[bidx] <= it_q.y_max;
      end
      if (cmd_i.do_add) begin
        if (cnt_q + 2'd2 <= EpCntW'(EpCap)) begin
          ep_q[cnt_q[EpIdxW-1:0]]        <= '{value: '0, is_min: 1'b1, owner: bidx};
          ep_q[cnt_q[EpIdxW-1:0] + 1'b1] <= '{value: '0, is_min: 1'b0, owner: bidx};
          cnt_q <= cnt_q + 2'd2;
        end
        present_q[bidx] <= 1'b1;
      end
      if (cmd_i.rm_start) begin
        ri_q <= '0;
        wi_q <= '0;
        for (int k = 0; k < MaxBodies; k++) begin
          pair_q[k][bidx] <= 1'b0;
          pair_q[bidx][k] <= 1'b0;
        end
      end
      // Compact: copy entries that do not belong to the removed body.
      if (cmd_i.rm_step) begin
        if (ep_q[ri_q[EpIdxW-1:0]].owner != bidx) begin
          ep_q[wi_q[EpIdxW-1:0]] <= ep_q[ri_q[EpIdxW-1:0]];
          wi_q <= wi_q + 1'b1;
        end
        ri_q <= ri_q + 1'b1;
      end
      if (cmd_i.rm_finish) begin
        for (int k = 0; k < EpCap; k++)
          if (EpCntW'(k) >= wi_q) ep_q[k] <= '0;
        cnt_q <= wi_q;
        present_q[bidx] <= 1'b0;
      end
      if (cmd_i.fill_step) begin
        ep_q[ri_q[EpIdxW-1:0]].value <= ep_q[ri_q[EpIdxW-1:0]].is_min ?
          xlo_q[ep_q[ri_q[EpIdxW-1:0]].owner] : xhi_q[ep_q[ri_q[EpIdxW-1:0]].owner];
        ri_q <= ri_q + 1'b1;
      end
      if (cmd_i.sort_init) ri_q <= EpCntW'(1);
      if (cmd_i.sort_load) wi_q <= ri_q;
      if (cmd_i.sort_next) ri_q <= ri_q + 1'b1;
      // Swap mover left past an equal-or-greater neighbor; track pairs.
      if (cmd_i.sort_step) begin
        if (mover.owner != left.owner) begin
          if (mover.is_min && !left.is_min) begin
            if (mover.owner < left.owner) pair_q[mover.owner][left.owner] <= 1'b1;
            else                          pair_q[left.owner][mover.owner] <= 1'b1;
          end
          if (!mover.is_min && left.is_min) begin
            if (mover.owner < left.owner) pair_q[mover.owner][left.owner] <= 1'b0;
            else                          pair_q[left.owner][mover.owner] <= 1'b0;
          end
        end
        ep_q[jidx] <= left;
        ep_q[jm1]  <= mover;
        wi_q <= wi_q - 1'b1;
      end
      if (cmd_i.q_init) begin
        qa_q   <= '0;
        qb_q   <= (BodyIdxW+1)'(1);
        qn_q   <= '0;
        qany_q <= 1'b0;
      end
      if (cmd_i.q_step) begin
        if (sts_o.q_hit) begin
          qn_q   <= qn_q + 1'b1;
          qany_q <= 1'b1;
        end
        if (qb_q + 1'b1 >= (BodyIdxW+1)'(MaxBodies)) begin
          qa_q <= qa_q + 1'b1;
          qb_q <= qa_q + 2'd2;
        end else begin
          qb_q <= qb_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/sap_ctrl.sv =====
// Controller of the sweep-and-prune broadphase: sequences actions, drives output.
// Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_ctrl import sap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  output cmd_t      cmd_o,
  input  sts_t      sts_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEC    = 9'b000000010,
    S_RM     = 9'b000000100,
    S_FILL   = 9'b000001000,
    S_SORTI  = 9'b000010000,
    S_SORTJ  = 9'b000100000,
    S_QUERY  = 9'b001000000,
    S_QHOLD  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e    state_q, state_d;
  logic      ov_q, ov_d;
  out_item_t oi_q, oi_d;
  logic      slot_free;

  assign slot_free   = !ov_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = oi_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && out_stall_i;
    oi_d    = oi_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (slot_free) begin
          oi_d = '{status: StOk, pair_valid: 1'b0, first_body: 3'd0,
                   second_body: 3'd0, last: 1'b1};
          state_d = S_IDLE;
          ov_d    = 1'b1;
          if (sts_i.action <= ActBounds && !sts_i.body_ok) begin
            oi_d.status = StAbsent;
          end else begin
            case (sts_i.action)
              ActAdd: begin
                if (sts_i.present) oi_d.status = StPresent;
                else cmd_o.do_add = 1'b1;
              end
              ActRemove: begin
                if (!sts_i.present) oi_d.status = StAbsent;
                else begin
                  cmd_o.rm_start = 1'b1;
                  ov_d    = ov_q && out_stall_i;
                  state_d = S_RM;
                end
              end
              ActBounds: cmd_o.do_bounds = 1'b1;
              ActSweep: begin
                cmd_o.ctr_clr = 1'b1;
                ov_d    = ov_q && out_stall_i;
                state_d = S_FILL;
              end
              ActQuery: begin
                cmd_o.q_init = 1'b1;
                ov_d    = ov_q && out_stall_i;
                state_d = S_QUERY;
              end
              default: ;
            endcase
          end
        end
      end
      S_RM: begin
        if (sts_i.rm_done) begin
          cmd_o.rm_finish = 1'b1;
          state_d = S_DONE;
        end else cmd_o.rm_step = 1'b1;
      end
      S_FILL: begin
        if (sts_i.fill_done) begin
          cmd_o.sort_init = 1'b1;
          state_d = S_SORTI;
        end else cmd_o.fill_step = 1'b1;
      end
      S_SORTI: begin
        if (sts_i.sort_done) state_d = S_DONE;
        else begin
          cmd_o.sort_load = 1'b1;
          state_d = S_SORTJ;
        end
      end
      S_SORTJ: begin
        if (sts_i.inner_done) begin
          cmd_o.sort_next = 1'b1;
          state_d = S_SORTI;
        end else cmd_o.sort_step = 1'b1;
      end
      // Scan one pair per cycle; a hit after the first waits for the output slot.
      S_QUERY: begin
        if (sts_i.q_done) begin
          if (!sts_i.q_any) state_d = S_DONE;
          else if (slot_free) begin
            // Pending hit held in oi_q is emitted with last set.
            state_d = S_IDLE;
            ov_d    = 1'b1;
            oi_d.last = 1'b1;
          end
        end else if (sts_i.q_hit) begin
          if (!sts_i.q_any) begin
            oi_d = '{status: StOk, pair_valid: 1'b1, first_body: sts_i.q_a,
                     second_body: sts_i.q_b, last: 1'b0};
            cmd_o.q_step = 1'b1;
          end else if (slot_free) begin
            ov_d = 1'b1;
            state_d = S_QHOLD;
          end
        end else cmd_o.q_step = 1'b1;
      end
      // Previous hit leaves; load the current one as pending, unless output stalls.
      S_QHOLD: begin
        oi_d = '{status: StOk, pair_valid: 1'b1, first_body: sts_i.q_a,
                 second_body: sts_i.q_b, last: 1'b0};
        cmd_o.q_step = 1'b1;
        state_d = S_QUERY;
        if (ov_q && out_stall_i) begin
          oi_d = oi_q;
          cmd_o.q_step = 1'b0;
          state_d = S_QHOLD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          oi_d = '{status: StOk, pair_valid: 1'b0, first_body: 3'd0,
                   second_body: 3'd0, last: 1'b1};
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oi_q <= oi_d;
  end

endmodule

// ===== src/sweep_and_prune_broadphase.sv =====
// Top level of the sweep-and-prune broadphase: controller plus datapath.
// Depends on sap_pkg, sap_ctrl, sap_datapath.
//
// Input channel in_valid_i / in_stall_o carries one action item (add, remove,
// bounds write, sweep, query). Output channel out_valid_o / out_stall_i
// carries result items; each action gives one result except a query, which
// gives one per reported pair with last set on the final one, or one if none.
// One item is worked at a time; in_stall_o is high from acceptance until the
// final result has been loaded into the output register.
// Add, bounds write and unknown actions are answered from decode; remove
// compacts the endpoint list, one endpoint compacted per cycle; sweep
// refreshes every endpoint value, then insertion-sorts the list by
// compare/swap steps with a check between outer passes; query scans the
// 28 pair slots and reports each pair whose bounds overlap.
// Within an outer pass, the endpoint list is updated one compare/swap a cycle.
// Reset clears bounds, presence, endpoint list and pair bits at once.
// A stalled output holds its item; the scan waits until the register frees.
`timescale 1ns / 1ps
module sweep_and_prune_broadphase import sap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  sap_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .out_item_o, .cmd_o(cmd), .sts_i(sts)
  );

  sap_datapath u_dp (
    .clk_i, .rst_ni, .item_i(in_item_i), .cmd_i(cmd), .sts_o(sts)
  );

endmodule

// ===== src/sap_checker.sv =====
// Port checker for the sweep-and-prune broadphase, bound to the top level.
// Depends on sap_pkg.
`timescale 1ns / 1ps
module sap_checker import sap_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Accepted item blocks further input next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Only pair results may lack last.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.pair_valid)
    else $error("non-pair result without last");

  // Pairs are ordered, never self, and carry status ok.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pair_valid |->
      out_item_o.first_body < out_item_o.second_body &&
      out_item_o.status == StOk)
    else $error("bad pair result");

endmodule

bind sweep_and_prune_broadphase sap_checker u_sap_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_item_o
);
